>>> rtl/owner_tagged_slot_pool_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot pool.
// The macros expand to concurrent assertions in simulation and to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef OWNER_TAGGED_SLOT_POOL_DEFINES_SVH
`define OWNER_TAGGED_SLOT_POOL_DEFINES_SVH

`ifndef SYNTHESIS
`define OSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool assertion failed");
`define OSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool assertion failed");
`else
`define OSP_ASSERT_IMP(lbl, ante, cons)
`define OSP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/osp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osp_pkg
// Types and constants shared by the owner tagged slot pool.
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam int POOL_SLOTS_DEF = 8;

  typedef enum logic [1:0] {
    OP_RESERVE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_HANDOVER = 2'd2,
    OP_CHECK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTOWNED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_FREE  = 2'd0,
    TAG_APP   = 2'd1,
    TAG_LINK  = 2'd2,
    TAG_STRAY = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CHK  = 2'd1,
    S_OUT  = 2'd2
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] slot_index;
    logic       requester;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] granted_slot;
  } out_word_t;

endpackage

>>> rtl/owner_tagged_slot_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_tagged_slot_pool
// Owner tags for a pool of frame slots: reserve, release, hand over, check.
// ----------------------------------------------------------------------------
// One request word enters on in_valid/in_ready and one result word leaves on
// out_valid/out_ready for every request. The block holds one request at a
// time: in_ready is high only while no request is in progress.
// A tag table in a single-port memory is read one entry a cycle by a small
// sequencer with one tag comparator. Release, hand over and check take one
// table read. A reserve that finds slot j scans j + 1 entries, and a full
// pool scans all POOL_SLOTS entries. An index outside the pool is answered
// without a table read, straight from the range check.
// Reset clears one valid flip-flop per slot, so every slot reads as free at
// once; no clearing pass is needed. A stalled receiver holds the result in
// the output register, and no new request is accepted until it is taken.
// ----------------------------------------------------------------------------
`include "owner_tagged_slot_pool_defines.svh"

module owner_tagged_slot_pool #(
  parameter int POOL_SLOTS = osp_pkg::POOL_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  osp_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output osp_pkg::out_word_t out_data
);

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_SLOTS - 1);

  osp_pkg::state_t    state_r, state_nxt;
  osp_pkg::op_t       op_r, op_nxt;
  logic               req_r, req_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  osp_pkg::out_word_t out_r, out_nxt;

  osp_pkg::tag_t      mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] valid_r;
  osp_pkg::tag_t      rd_data_r;
  logic               rd_valid_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  osp_pkg::tag_t      wr_data;

  osp_pkg::tag_t      entry;
  osp_pkg::tag_t      me;
  osp_pkg::tag_t      other;
  logic [7:0]         k_ext;

  assign entry = rd_valid_r ? rd_data_r : osp_pkg::TAG_FREE;
  assign me    = req_r ? osp_pkg::TAG_LINK : osp_pkg::TAG_APP;
  assign other = req_r ? osp_pkg::TAG_APP : osp_pkg::TAG_LINK;
  assign k_ext = 8'(k_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[k_r] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    rd_valid_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[k_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= osp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r  <= op_nxt;
    req_r <= req_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    req_nxt   = req_r;
    k_nxt     = k_r;
    out_nxt   = out_r;
    rd_addr   = k_r;
    wr_en     = 1'b0;
    wr_data   = osp_pkg::TAG_FREE;
    case (state_r)
      osp_pkg::S_IDLE: begin
        if (in_data.op == osp_pkg::OP_RESERVE) begin
          rd_addr = '0;
        end else begin
          rd_addr = in_data.slot_index[IDX_W-1:0];
        end
        if (in_valid) begin
          op_nxt  = in_data.op;
          req_nxt = in_data.requester;
          k_nxt   = rd_addr;
          out_nxt.granted_slot = '0;
          if (in_data.op != osp_pkg::OP_RESERVE &&
              {1'b0, in_data.slot_index} >= 9'(POOL_SLOTS)) begin
            out_nxt.status = osp_pkg::ST_RANGE;
            state_nxt      = osp_pkg::S_OUT;
          end else begin
            state_nxt = osp_pkg::S_CHK;
          end
        end
      end
      osp_pkg::S_CHK: begin
        out_nxt.status       = osp_pkg::ST_DONE;
        out_nxt.granted_slot = '0;
        state_nxt            = osp_pkg::S_OUT;
        if (op_r == osp_pkg::OP_RESERVE) begin
          if (entry == osp_pkg::TAG_FREE) begin
            wr_en   = 1'b1;
            wr_data = me;
            out_nxt.granted_slot = k_ext[2:0];
          end else if (k_r == LAST) begin
            out_nxt.status = osp_pkg::ST_FULL;
          end else begin
            k_nxt     = k_r + 1'b1;
            rd_addr   = k_r + 1'b1;
            state_nxt = osp_pkg::S_CHK;
          end
        end else if (entry != me) begin
          out_nxt.status = osp_pkg::ST_NOTOWNED;
        end else if (op_r == osp_pkg::OP_RELEASE) begin
          wr_en   = 1'b1;
          wr_data = osp_pkg::TAG_FREE;
        end else if (op_r == osp_pkg::OP_HANDOVER) begin
          wr_en   = 1'b1;
          wr_data = other;
        end
      end
      osp_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = osp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = osp_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == osp_pkg::S_IDLE);
  assign out_valid = (state_r == osp_pkg::S_OUT);
  assign out_data  = out_r;

  `OSP_ASSERT_IMP(a_one_in_flight, in_ready, !out_valid)
  `OSP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `OSP_ASSERT_IMP(a_grant_only_on_done,
                  out_valid && out_data.status != osp_pkg::ST_DONE,
                  out_data.granted_slot == 3'd0)

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the owner tagged slot pool. A behavioral copy of
// the owner table predicts the status and granted slot of every request word.
// A directed sequence covers the corner cases, and random traffic follows.
// The random traffic draws a new share of reserve requests every 40 words and
// includes one long receiver stall. Result words are checked in order as
// they leave the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS        = osp_pkg::POOL_SLOTS_DEF;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  osp_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  osp_pkg::out_word_t out_data;

  osp_pkg::tag_t      slot_tag [SLOTS];
  osp_pkg::out_word_t pending_results [$];
  int                 mismatches   = 0;
  int                 cycle_count  = 0;
  int                 burst_left   = 0;
  bit                 hold_request = 1'b0;

  owner_tagged_slot_pool #(
    .POOL_SLOTS(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic osp_pkg::out_word_t apply_request(osp_pkg::in_word_t req);
    osp_pkg::out_word_t res;
    osp_pkg::tag_t      mine;
    int                 idx;
    mine = req.requester ? osp_pkg::TAG_LINK : osp_pkg::TAG_APP;
    idx = int'(req.slot_index);
    res.status = osp_pkg::ST_DONE;
    res.granted_slot = '0;
    if (req.op == osp_pkg::OP_RESERVE) begin
      res.status = osp_pkg::ST_FULL;
      for (int k = 0; k < SLOTS; k++) begin
        if (slot_tag[k] == osp_pkg::TAG_FREE) begin
          slot_tag[k] = mine;
          res.status = osp_pkg::ST_DONE;
          res.granted_slot = 3'(k);
          break;
        end
      end
    end else if (idx >= SLOTS) begin
      res.status = osp_pkg::ST_RANGE;
    end else if (slot_tag[idx] != mine) begin
      res.status = osp_pkg::ST_NOTOWNED;
    end else if (req.op == osp_pkg::OP_RELEASE) begin
      slot_tag[idx] = osp_pkg::TAG_FREE;
    end else if (req.op == osp_pkg::OP_HANDOVER) begin
      slot_tag[idx] = (mine == osp_pkg::TAG_APP) ? osp_pkg::TAG_LINK : osp_pkg::TAG_APP;
    end
    return res;
  endfunction

  function automatic osp_pkg::in_word_t pick_request(int reserve_weight);
    osp_pkg::in_word_t req;
    osp_pkg::tag_t     mine;
    int                owned [$];
    int                roll;
    req.requester = 1'($urandom_range(0, 1));
    mine = req.requester ? osp_pkg::TAG_LINK : osp_pkg::TAG_APP;
    roll = $urandom_range(0, 99);
    if (roll < reserve_weight) begin
      req.op = osp_pkg::OP_RESERVE;
    end else begin
      req.op = osp_pkg::op_t'($urandom_range(1, 3));
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_tag[k] == mine) begin
        owned.push_back(k);
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 70 && owned.size() != 0) begin
      req.slot_index = 8'(owned[$urandom_range(0, owned.size() - 1)]);
    end else if (roll < 90) begin
      req.slot_index = 8'($urandom_range(0, SLOTS - 1));
    end else begin
      req.slot_index = 8'($urandom_range(0, 255));
    end
    return req;
  endfunction

  task automatic send_word(osp_pkg::in_word_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(req));
    burst_left--;
  endtask

  task automatic send_fields(osp_pkg::op_t op, logic [7:0] idx, logic who);
    osp_pkg::in_word_t req;
    req.op = op;
    req.slot_index = idx;
    req.requester = who;
    send_word(req);
  endtask

  task automatic sender_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_fields(osp_pkg::OP_CHECK, 8'd0, 1'b0);
    for (int k = 0; k < SLOTS; k++) begin
      send_fields(osp_pkg::OP_RESERVE, 8'(k * 37), 1'(k));
    end
    send_fields(osp_pkg::OP_RESERVE, 8'd255, 1'b0);
    send_fields(osp_pkg::OP_RESERVE, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_RELEASE, 8'(SLOTS), 1'b0);
    send_fields(osp_pkg::OP_HANDOVER, 8'd255, 1'b1);
    send_fields(osp_pkg::OP_CHECK, 8'd128, 1'b0);
    send_fields(osp_pkg::OP_CHECK, 8'd0, 1'b0);
    send_fields(osp_pkg::OP_CHECK, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_CHECK, 8'd1, 1'b1);
    send_fields(osp_pkg::OP_HANDOVER, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_HANDOVER, 8'd0, 1'b0);
    send_fields(osp_pkg::OP_CHECK, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_RELEASE, 8'd0, 1'b0);
    send_fields(osp_pkg::OP_RELEASE, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_RELEASE, 8'd3, 1'b1);
    send_fields(osp_pkg::OP_CHECK, 8'd0, 1'b1);
    send_fields(osp_pkg::OP_RESERVE, 8'd7, 1'b0);
    send_fields(osp_pkg::OP_RESERVE, 8'd7, 1'b1);
    sender_idle();
  endtask

  task automatic test_random_traffic(int count);
    int weight;
    weight = 35;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        weight = $urandom_range(10, 65);
      end
      send_word(pick_request(weight));
    end
    sender_idle();
  endtask

  task automatic test_long_stall(int count);
    hold_request = 1'b1;
    for (int n = 0; n < count; n++) begin
      send_word(pick_request(35));
    end
    sender_idle();
  endtask

  initial begin : result_receiver
    rx_mode_t mode;
    int       left;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          RX_OPEN: begin
            out_ready <= 1'b1;
          end
          RX_MOSTLY: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          RX_SPARSE: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    osp_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, status %0d granted_slot %0d", $time,
                 out_data.status, out_data.granted_slot);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data.status);
        end
        if (out_data.granted_slot !== want.granted_slot) begin
          mismatches++;
          $display("%0t: granted_slot expected %0d actual %0d", $time,
                   want.granted_slot, out_data.granted_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (slot_tag[k]) begin
      slot_tag[k] = osp_pkg::TAG_FREE;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(1000);
    test_long_stall(600);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/osp_pkg.sv
rtl/owner_tagged_slot_pool.sv
test/tb_top.sv
